[src/ark2_pkg.sv]
// ark2_pkg: shared types, codes and saturating fixed-point helpers
// for the attractor rk2 integrator; no dependencies
package ark2_pkg;

  // system mode codes
  localparam logic [2:0] MODE_LORENZ   = 3'd0;
  localparam logic [2:0] MODE_ROSSLER  = 3'd1;
  localparam logic [2:0] MODE_CONE     = 3'd2;
  localparam logic [2:0] MODE_BIRKHOFF = 3'd3;
  localparam logic [2:0] MODE_DUFFING  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_A    = 3'd1;
  localparam logic [2:0] REG_B    = 3'd2;
  localparam logic [2:0] REG_C    = 3'd3;
  localparam logic [2:0] REG_STEP = 3'd4;

  // angle constants at 30 fraction bits
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_GAIN    = 64'sd652032874;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [16:0]        h;
  } coef_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] v;
  } sat_t;

  function automatic logic signed [65:0] wx(input logic signed [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic sat_t sat64(input logic signed [65:0] w);
    sat_t r;
    if (w > 66'sd2147483647) begin
      r.ovf = 1'b1;
      r.v   = 32'sh7FFFFFFF;
    end else if (w < -66'sd2147483648) begin
      r.ovf = 1'b1;
      r.v   = 32'sh80000000;
    end else begin
      r.ovf = 1'b0;
      r.v   = w[31:0];
    end
    return r;
  endfunction

  function automatic sat_t sadd(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat64(wx(a) + wx(b));
  endfunction

  function automatic sat_t ssub(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat64(wx(a) - wx(b));
  endfunction

  function automatic sat_t sneg(input logic signed [31:0] a);
    return sat64(66'sd0 - wx(a));
  endfunction

  // rescale a full product by the fraction bits, floor rounding, then saturate
  function automatic sat_t mulsat(input logic signed [63:0] p, input int unsigned f);
    logic signed [63:0] s;
    s = p >>> f;
    return sat64({{2{s[63]}}, s});
  endfunction

endpackage

[src/attractor_rk2_integrator.sv]
// attractor_rk2_integrator: top level, one heun step of a strange-attractor flow
// depends on ark2_pkg, ark2_delay, ark2_sincos, ark2_field
//
// throughput: one transaction per cycle, busy is raised only during reset
// the pipeline runs through the front stages, the cordic stages and two five-stage field pipelines
// reset (rst, synchronous): clears every valid bit in flight and restores register defaults
module attractor_rk2_integrator #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ark2_pkg::in_t   in_item,
  output logic            result_valid,
  output ark2_pkg::out_t  result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int unsigned F = FRAC_BITS;
  localparam int L   = 4 + CORDIC_ITERS;  // sincos pipeline depth
  localparam int LF  = 5;                 // field pipeline depth
  localparam int LAT = 17 + L;
  localparam logic signed [31:0] A_RST = 32'(64'sd10 <<< F);
  localparam logic signed [31:0] B_RST = 32'(64'sd28 <<< F);
  localparam logic signed [31:0] C_RST = 32'(64'sd2 <<< F);
  localparam logic [16:0]        H_RST = 17'd1311;

  // configuration registers
  ark2_pkg::coef_t coef;

  // front stages: capture, h*c product, second phase
  logic               s0_valid, s1_valid, s2_valid;
  ark2_pkg::vec_t     s0_p, s1_p, s2_p;
  logic signed [63:0] s1_hc;
  logic signed [31:0] s2_ang;
  logic signed [31:0] hs;
  ark2_pkg::sat_t     hc_s, ang_s;

  // sincos outputs for the two evaluation points
  logic signed [31:0] sn_a, cs_a, sn_b, cs_b;

  // aligned with sincos output
  logic           a_valid;
  ark2_pkg::vec_t a_p;

  // first field evaluation
  logic           f1_valid;
  ark2_pkg::vec_t f1_d;
  logic           f1_ovf;
  logic           d2_valid;
  logic [159:0]   d2_data;
  ark2_pkg::vec_t d2_p;
  logic signed [31:0] d2_sn, d2_cs;

  // k1 product and p2 stage
  logic               k1_valid;
  logic signed [63:0] k1_prod [3];
  logic signed [31:0] k1_base [3];
  logic signed [31:0] k1_sn, k1_cs;
  logic               k1_ovf;
  logic               p2_valid;
  logic signed [31:0] p2_base [3];
  logic signed [31:0] p2_k1 [3];
  logic signed [31:0] p2_pt [3];
  logic signed [31:0] p2_sn, p2_cs;
  logic               p2_ovf;
  ark2_pkg::sat_t     k1_s [3];
  ark2_pkg::sat_t     p2_s [3];
  logic               p2_f;
  ark2_pkg::vec_t     p2_vec;

  // second field evaluation
  logic           f2_valid;
  ark2_pkg::vec_t f2_d;
  logic           f2_ovf;
  logic           d3_valid;
  logic [192:0]   d3_data;
  logic signed [31:0] d3_base [3];
  logic signed [31:0] d3_k1 [3];
  logic           d3_ovf;

  // k2 product and final sum
  logic               k2_valid;
  logic signed [63:0] k2_prod [3];
  logic signed [31:0] k2_base [3];
  logic signed [31:0] k2_k1 [3];
  logic               k2_ovf;
  ark2_pkg::sat_t     k2_s [3];
  ark2_pkg::sat_t     o_s [3];
  logic signed [32:0] ksum [3];
  logic signed [32:0] khalf [3];
  logic               o_f;

  logic signed [31:0] d1_arr [3];
  logic signed [31:0] d2_arr [3];
  logic signed [31:0] a_arr [3];

  // the pipeline refuses a transaction only while in reset
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.mode <= ark2_pkg::MODE_LORENZ;
      coef.a    <= A_RST;
      coef.b    <= B_RST;
      coef.c    <= C_RST;
      coef.h    <= H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ark2_pkg::REG_MODE: coef.mode <= cfg_data[2:0];
        ark2_pkg::REG_A:    coef.a    <= cfg_data;
        ark2_pkg::REG_B:    coef.b    <= cfg_data;
        ark2_pkg::REG_C:    coef.c    <= cfg_data;
        ark2_pkg::REG_STEP: coef.h    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // step size as a signed operand
  assign hs = signed'({15'b0, coef.h});

  // second phase is z + h*c in the sincos modes; the generic path recomputes it
  // with flags, so only the value is taken here
  always_comb begin
    hc_s  = ark2_pkg::mulsat(s1_hc, F);
    ang_s = ark2_pkg::sadd(s1_p.z, hc_s.v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_p.x <= in_item.pos_x;
    s0_p.y <= in_item.pos_y;
    s0_p.z <= in_item.pos_z;
    s1_p   <= s0_p;
    s1_hc  <= hs * coef.c;
    s2_p   <= s1_p;
    s2_ang <= ang_s.v;
  end

  ark2_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_ITERS(CORDIC_ITERS)) u_sincos_a (
    .clk   (clk),
    .angle (s2_p.z),
    .sn    (sn_a),
    .cs    (cs_a)
  );

  ark2_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_ITERS(CORDIC_ITERS)) u_sincos_b (
    .clk   (clk),
    .angle (s2_ang),
    .sn    (sn_b),
    .cs    (cs_b)
  );

  // hold the position while the cordic runs
  ark2_delay #(.W(96), .N(L)) u_dly_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_data   (s2_p),
    .out_valid (a_valid),
    .out_data  (a_p)
  );

  ark2_field #(.FRAC_BITS(FRAC_BITS)) u_field_1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_p      (a_p),
    .in_sn     (sn_a),
    .in_cs     (cs_a),
    .coef      (coef),
    .out_valid (f1_valid),
    .out_d     (f1_d),
    .out_ovf   (f1_ovf)
  );

  // position and second sincos ride alongside the first field pass
  ark2_delay #(.W(160), .N(LF)) u_dly_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_data   ({a_p, sn_b, cs_b}),
    .out_valid (d2_valid),
    .out_data  (d2_data)
  );

  assign d2_p  = d2_data[159:64];
  assign d2_sn = d2_data[63:32];
  assign d2_cs = d2_data[31:0];

  assign d1_arr[0] = f1_d.x;
  assign d1_arr[1] = f1_d.y;
  assign d1_arr[2] = f1_d.z;
  assign a_arr[0]  = d2_p.x;
  assign a_arr[1]  = d2_p.y;
  assign a_arr[2]  = d2_p.z;

  // k1 = h * f(p), then p2 = p + k1
  always_comb begin
    p2_f = k1_ovf;
    for (int i = 0; i < 3; i++) begin
      k1_s[i] = ark2_pkg::mulsat(k1_prod[i], F);
      p2_s[i] = ark2_pkg::sadd(k1_base[i], k1_s[i].v);
      p2_f    = p2_f | k1_s[i].ovf | p2_s[i].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      k1_valid <= f1_valid;
      p2_valid <= k1_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      k1_prod[i] <= 64'(hs) * 64'(d1_arr[i]);
      k1_base[i] <= a_arr[i];
      p2_base[i] <= k1_base[i];
      p2_k1[i]   <= k1_s[i].v;
      p2_pt[i]   <= p2_s[i].v;
    end
    k1_sn  <= d2_sn;
    k1_cs  <= d2_cs;
    k1_ovf <= f1_ovf;
    p2_sn  <= k1_sn;
    p2_cs  <= k1_cs;
    p2_ovf <= p2_f;
  end

  assign p2_vec.x = p2_pt[0];
  assign p2_vec.y = p2_pt[1];
  assign p2_vec.z = p2_pt[2];

  ark2_field #(.FRAC_BITS(FRAC_BITS)) u_field_2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p2_valid),
    .in_p      (p2_vec),
    .in_sn     (p2_sn),
    .in_cs     (p2_cs),
    .coef      (coef),
    .out_valid (f2_valid),
    .out_d     (f2_d),
    .out_ovf   (f2_ovf)
  );

  ark2_delay #(.W(193), .N(LF)) u_dly_c (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p2_valid),
    .in_data   ({p2_base[0], p2_base[1], p2_base[2],
                 p2_k1[0], p2_k1[1], p2_k1[2], p2_ovf}),
    .out_valid (d3_valid),
    .out_data  (d3_data)
  );

  assign d3_base[0] = d3_data[192:161];
  assign d3_base[1] = d3_data[160:129];
  assign d3_base[2] = d3_data[128:97];
  assign d3_k1[0]   = d3_data[96:65];
  assign d3_k1[1]   = d3_data[64:33];
  assign d3_k1[2]   = d3_data[32:1];
  assign d3_ovf     = d3_data[0];

  assign d2_arr[0] = f2_d.x;
  assign d2_arr[1] = f2_d.y;
  assign d2_arr[2] = f2_d.z;

  // k2 = h * f(p2), result = p + (k1 + k2) / 2 with the sum kept exact
  always_comb begin
    o_f = k2_ovf;
    for (int i = 0; i < 3; i++) begin
      k2_s[i]  = ark2_pkg::mulsat(k2_prod[i], F);
      ksum[i]  = {k2_k1[i][31], k2_k1[i]} + {k2_s[i].v[31], k2_s[i].v};
      khalf[i] = ksum[i] >>> 1;
      o_s[i]   = ark2_pkg::sat64(ark2_pkg::wx(k2_base[i]) + {{33{khalf[i][32]}}, khalf[i]});
      o_f      = o_f | k2_s[i].ovf | o_s[i].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      k2_valid     <= f2_valid;
      result_valid <= k2_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      k2_prod[i] <= 64'(hs) * 64'(d2_arr[i]);
      k2_base[i] <= d3_base[i];
      k2_k1[i]   <= d3_k1[i];
    end
    k2_ovf          <= f2_ovf | d3_ovf;
    result.next_x   <= o_s[0].v;
    result.next_y   <= o_s[1].v;
    result.next_z   <= o_s[2].v;
    result.overflow <= o_f;
  end

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT result_valid)
    else $error("result strobe missing after pipeline latency");

  // side data must line up with the first field pass
  a_align_1: assert property (@(posedge clk) disable iff (rst)
    f1_valid == d2_valid)
    else $error("first field pass out of step with its side data");

  // and with the second field pass
  a_align_2: assert property (@(posedge clk) disable iff (rst)
    f2_valid == d3_valid)
    else $error("second field pass out of step with its side data");

endmodule

[src/ark2_delay.sv]
// ark2_delay: fixed-length delay line for a valid bit and its payload
// depends on nothing
module ark2_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [N-1:0] vld;
  logic [W-1:0] dat [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < N; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dat[0] <= in_data;
    for (int i = 1; i < N; i++) dat[i] <= dat[i-1];
  end

  assign out_valid = vld[N-1];
  assign out_data  = dat[N-1];

endmodule

[src/ark2_sincos.sv]
// ark2_sincos: pipelined angle reduction and rotation-mode cordic
// depends on ark2_pkg
module ark2_sincos #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic signed [31:0] angle,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  localparam int SH  = 30 - FRAC_BITS;
  localparam int ZW  = 32 + SH;
  localparam int QW  = 32 - FRAC_BITS;
  localparam int QSH = 32 + FRAC_BITS;
  localparam int N   = CORDIC_ITERS;
  localparam longint RECIP64 = (64'sd1 <<< 62) / ark2_pkg::Q30_TWO_PI;
  localparam logic signed [31:0] RECIP     = 32'(RECIP64);
  localparam logic signed [34:0] TWO_PI_S  = 35'(ark2_pkg::Q30_TWO_PI);
  localparam logic signed [34:0] PI_S      = 35'(ark2_pkg::Q30_PI);
  localparam logic signed [34:0] HALF_PI_S = 35'(ark2_pkg::Q30_HALF_PI);
  localparam logic signed [33:0] GAIN_S    = 34'(ark2_pkg::Q30_GAIN);

  logic signed [63:0]   s0_prod;
  logic signed [ZW-1:0] s0_z30;
  logic signed [ZW+1:0] s1_qp;
  logic signed [ZW-1:0] s1_z30;
  logic signed [34:0]   s2_r;

  logic signed [QW-1:0]    qn;
  logic signed [QW+34:0]   qprod;
  logic signed [ZW+1:0]    r_raw;
  logic signed [ZW+1:0]    r_fix;
  logic signed [34:0]      r_ctr;
  logic signed [34:0]      r_fold;
  logic                    flip;

  logic signed [33:0] cx [N+1];
  logic signed [33:0] cy [N+1];
  logic signed [34:0] cr [N+1];
  logic               cf [N+1];
  logic signed [33:0] xf;

  // quotient estimate by reciprocal, then exact remainder
  always_comb begin
    qn    = QW'(s0_prod >>> QSH);
    qprod = qn * TWO_PI_S;
    r_raw = (ZW+2)'(s1_z30) - s1_qp;
    if (r_raw < 0)                      r_fix = r_raw + (ZW+2)'(TWO_PI_S);
    else if (r_raw >= (ZW+2)'(TWO_PI_S)) r_fix = r_raw - (ZW+2)'(TWO_PI_S);
    else                                r_fix = r_raw;
    r_ctr = (s2_r > PI_S) ? s2_r - TWO_PI_S : s2_r;
    flip  = 1'b0;
    if (r_ctr > HALF_PI_S) begin
      r_fold = PI_S - r_ctr;
      flip   = 1'b1;
    end else if (r_ctr < -HALF_PI_S) begin
      r_fold = -PI_S - r_ctr;
      flip   = 1'b1;
    end else begin
      r_fold = r_ctr;
    end
  end

  always_ff @(posedge clk) begin
    s0_prod <= 64'(angle) * 64'(RECIP);
    s0_z30  <= ZW'(angle) <<< SH;
    s1_qp   <= qprod[ZW+1:0];
    s1_z30  <= s0_z30;
    s2_r    <= r_fix[34:0];
  end

  // folded angle enters, then one micro-rotation per stage
  always_ff @(posedge clk) begin
    cx[0] <= GAIN_S;
    cy[0] <= '0;
    cr[0] <= r_fold;
    cf[0] <= flip;
    for (int i = 0; i < N; i++) begin
      cf[i+1] <= cf[i];
      if (cr[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cr[i+1] <= cr[i] - $signed({3'b000, ark2_pkg::ATAN_Q30[i]});
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cr[i+1] <= cr[i] + $signed({3'b000, ark2_pkg::ATAN_Q30[i]});
      end
    end
  end

  assign xf = cf[N] ? -cx[N] : cx[N];
  assign sn = 32'(cy[N] >>> SH);
  assign cs = 32'(xf >>> SH);

endmodule

[src/ark2_field.sv]
// ark2_field: five-stage pipelined evaluation of the selected vector field
// depends on ark2_pkg
module ark2_field #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ark2_pkg::vec_t       in_p,
  input  logic signed [31:0]   in_sn,
  input  logic signed [31:0]   in_cs,
  input  ark2_pkg::coef_t      coef,
  output logic                 out_valid,
  output ark2_pkg::vec_t       out_d,
  output logic                 out_ovf
);

  localparam int unsigned F = FRAC_BITS;
  localparam logic signed [31:0] K57 = 32'(((64'sd57 <<< F) + 5) / 10);
  localparam logic signed [31:0] K02 = 32'(((64'sd2 <<< F) + 5) / 10);
  localparam logic signed [31:0] K07 = 32'(((64'sd7 <<< F) + 5) / 10);
  localparam logic signed [31:0] K01 = 32'(((64'sd1 <<< F) + 5) / 10);
  localparam logic signed [31:0] K20 = 32'(64'sd2 <<< F);

  logic [4:0] vld;

  // stage 0: operand select
  logic signed [31:0] ma [4];
  logic signed [31:0] mb [4];
  logic               f0;
  logic signed [31:0] r0_a [4];
  logic signed [31:0] r0_b [4];
  logic signed [31:0] r0_x, r0_y;
  logic               r0_o;
  // stage 1: products
  logic signed [63:0] r1_p [4];
  logic signed [31:0] r1_x, r1_y;
  logic               r1_o;
  // stage 2: rescale, second-level operands
  ark2_pkg::sat_t     ms [4];
  ark2_pkg::sat_t     tt;
  logic               f2;
  logic signed [31:0] la, lb;
  logic signed [31:0] r2_m [4];
  logic signed [31:0] r2_la, r2_lb, r2_x, r2_y;
  logic               r2_o;
  // stage 3: second-level product, partial sums
  ark2_pkg::sat_t     e0, e1, e2, e3;
  logic signed [31:0] q0, q1, q2, qa;
  logic               f3;
  logic signed [63:0] r3_l;
  logic signed [31:0] r3_q0, r3_q1, r3_q2, r3_qa;
  logic               r3_o;
  // stage 4: finish
  ark2_pkg::sat_t     l2s, g0, g1;
  logic signed [31:0] d0, d1;
  logic               f4;
  ark2_pkg::vec_t     r4_d;
  logic               r4_o;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    e0 = '0;
    e1 = '0;
    f0 = 1'b0;
    case (coef.mode)
      ark2_pkg::MODE_ROSSLER, ark2_pkg::MODE_CONE: begin
        e0 = ark2_pkg::ssub(in_p.x, K57);
        f0 = e0.ovf;
        ma[0] = coef.a;  mb[0] = in_p.z;
        ma[1] = in_p.y;  mb[1] = coef.b;
        ma[2] = in_p.z;  mb[2] = e0.v;
        if (coef.mode == ark2_pkg::MODE_CONE) begin
          ma[3] = in_p.z;  mb[3] = in_p.z;
        end
      end
      ark2_pkg::MODE_BIRKHOFF: begin
        ma[0] = coef.b;  mb[0] = in_sn;
        ma[1] = K07;     mb[1] = in_p.x;
        ma[2] = coef.a;  mb[2] = in_p.y;
        ma[3] = in_p.x;  mb[3] = in_p.x;
      end
      ark2_pkg::MODE_DUFFING: begin
        e0 = ark2_pkg::sneg(coef.a);
        f0 = e0.ovf;
        ma[0] = e0.v;    mb[0] = in_p.x;
        ma[1] = in_p.y;  mb[1] = in_p.y;
        ma[2] = coef.b;  mb[2] = in_cs;
        ma[3] = K20;     mb[3] = in_p.x;
      end
      default: begin
        e0 = ark2_pkg::ssub(in_p.y, in_p.x);
        e1 = ark2_pkg::ssub(coef.b, in_p.z);
        f0 = e0.ovf | e1.ovf;
        ma[0] = coef.a;  mb[0] = e0.v;
        ma[1] = in_p.x;  mb[1] = e1.v;
        ma[2] = in_p.x;  mb[2] = in_p.y;
        ma[3] = coef.c;  mb[3] = in_p.z;
      end
    endcase
  end

  always_comb begin
    f2 = r1_o;
    for (int i = 0; i < 4; i++) begin
      ms[i] = ark2_pkg::mulsat(r1_p[i], F);
      f2 = f2 | ms[i].ovf;
    end
    tt = ark2_pkg::ssub(K01, ms[3].v);
    la = '0;
    lb = '0;
    case (coef.mode)
      ark2_pkg::MODE_CONE: begin
        la = ms[3].v;  lb = coef.c;
      end
      ark2_pkg::MODE_BIRKHOFF: begin
        f2 = f2 | tt.ovf;
        la = ms[2].v;  lb = tt.v;
      end
      ark2_pkg::MODE_DUFFING: begin
        la = ms[1].v;  lb = r1_y;
      end
      default: begin
        la = '0;
        lb = '0;
      end
    endcase
  end

  always_comb begin
    e2 = '0;
    e3 = '0;
    qa = '0;
    f3 = r2_o;
    case (coef.mode)
      ark2_pkg::MODE_ROSSLER, ark2_pkg::MODE_CONE: begin
        e2 = ark2_pkg::sadd(r2_y, r2_m[0]);
        e3 = ark2_pkg::sneg(e2.v);
        q0 = e3.v;
        f3 = f3 | e2.ovf | e3.ovf;
        e2 = ark2_pkg::sadd(r2_x, r2_m[1]);
        q1 = e2.v;
        f3 = f3 | e2.ovf;
        if (coef.mode == ark2_pkg::MODE_CONE) e3 = ark2_pkg::sadd(K02, r2_m[2]);
        else                                  e3 = ark2_pkg::sadd(coef.c, r2_m[2]);
        q2 = e3.v;
        f3 = f3 | e3.ovf;
      end
      ark2_pkg::MODE_BIRKHOFF: begin
        e2 = ark2_pkg::sneg(r2_y);
        e3 = ark2_pkg::sadd(e2.v, r2_m[0]);
        q0 = e3.v;
        f3 = f3 | e2.ovf | e3.ovf;
        q1 = r2_m[1];
        q2 = coef.c;
      end
      ark2_pkg::MODE_DUFFING: begin
        e2 = ark2_pkg::ssub(r2_m[0], r2_y >>> 1);
        q0 = e2.v;
        f3 = f3 | e2.ovf;
        qa = r2_m[2];
        q1 = r2_m[3];
        q2 = coef.c;
      end
      default: begin
        q0 = r2_m[0];
        e2 = ark2_pkg::ssub(r2_m[1], r2_y);
        e3 = ark2_pkg::ssub(r2_m[2], r2_m[3]);
        q1 = e2.v;
        q2 = e3.v;
        f3 = f3 | e2.ovf | e3.ovf;
      end
    endcase
  end

  always_comb begin
    l2s = ark2_pkg::mulsat(r3_l, F);
    f4  = r3_o | l2s.ovf;
    g0  = '0;
    g1  = '0;
    d0  = r3_q0;
    d1  = r3_q1;
    case (coef.mode)
      ark2_pkg::MODE_CONE: begin
        g0 = ark2_pkg::ssub(r3_q1, l2s.v);
        d1 = g0.v;
        f4 = f4 | g0.ovf;
      end
      ark2_pkg::MODE_BIRKHOFF: begin
        g0 = ark2_pkg::sadd(r3_q1, l2s.v);
        d1 = g0.v;
        f4 = f4 | g0.ovf;
      end
      ark2_pkg::MODE_DUFFING: begin
        g0 = ark2_pkg::ssub(r3_q0, l2s.v >>> 3);
        g1 = ark2_pkg::sadd(g0.v, r3_qa);
        d0 = g1.v;
        f4 = f4 | g0.ovf | g1.ovf;
      end
      default: begin
        d0 = r3_q0;
        d1 = r3_q1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      r0_a[i] <= ma[i];
      r0_b[i] <= mb[i];
      r1_p[i] <= r0_a[i] * r0_b[i];
      r2_m[i] <= ms[i].v;
    end
    r0_x  <= in_p.x;
    r0_y  <= in_p.y;
    r0_o  <= f0;
    r1_x  <= r0_x;
    r1_y  <= r0_y;
    r1_o  <= r0_o;
    r2_la <= la;
    r2_lb <= lb;
    r2_x  <= r1_x;
    r2_y  <= r1_y;
    r2_o  <= f2;
    r3_l  <= r2_la * r2_lb;
    r3_q0 <= q0;
    r3_q1 <= q1;
    r3_q2 <= q2;
    r3_qa <= qa;
    r3_o  <= f3;
    r4_d.x <= d0;
    r4_d.y <= d1;
    r4_d.z <= r3_q2;
    r4_o  <= f4;
  end

  assign out_valid = vld[4];
  assign out_d     = r4_d;
  assign out_ovf   = r4_o;

endmodule
